[rtl/core/sta_pkg.sv]
// Shared types, codes and defaults for the slot table allocator.
package sta_pkg;

    // Default sizing of the table.
    localparam int STA_SLOT_COUNT   = 16;
    localparam int STA_HANDLE_WIDTH = 32;

    // Widths fixed by the stream payload.
    localparam int STA_IDX_W    = 8;
    localparam int STA_HDL_W    = 32;
    localparam int STA_CNT_W    = 9;
    localparam int STA_IN_DW    = 40;
    localparam int STA_OUT_DW   = 56;

    // Operation codes carried in the input tuser.
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_GET     = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Control states of the top level.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } t_state;

    // Update request into the occupancy tracker.
    typedef struct packed {
        logic                 alloc;
        logic                 rel;
        logic [STA_IDX_W-1:0] idx;
    } t_occ_upd;

    // Status from the occupancy tracker.
    typedef struct packed {
        logic                 full;
        logic [STA_IDX_W-1:0] free_idx;
        logic                 query_occ;
    } t_occ_stat;

endpackage

[rtl/core/sta_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module sta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/sta_occupancy.sv]
// Occupancy bitmap, occupied-slot count and lowest-free-slot encoder.
module sta_occupancy
    import sta_pkg::*;
#(
    parameter int SLOT_COUNT = STA_SLOT_COUNT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_occ_upd                         i_upd,
    input  logic [STA_IDX_W-1:0]             i_query_idx,
    output t_occ_stat                        o_stat,
    output logic [$clog2(SLOT_COUNT+1)-1:0]  o_count
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    logic [SLOT_COUNT-1:0] r_bitmap;
    logic [CW-1:0]         r_count;
    logic [STA_IDX_W-1:0]  w_free_idx;

    // Lowest clear bit of the bitmap; unused when the table is full.
    always_comb begin
        w_free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_bitmap[i]) begin
                w_free_idx = STA_IDX_W'(i);
            end
        end
    end

    // Bitmap and count update; a release is sent only for a held slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitmap <= '0;
            r_count  <= '0;
        end else if (i_upd.alloc) begin
            r_bitmap[i_upd.idx[AW-1:0]] <= 1'b1;
            r_count                     <= r_count + CW'(1);
        end else if (i_upd.rel) begin
            r_bitmap[i_upd.idx[AW-1:0]] <= 1'b0;
            r_count                     <= r_count - CW'(1);
        end
    end

    assign o_stat.full      = (r_count >= CW'(SLOT_COUNT));
    assign o_stat.free_idx  = w_free_idx;
    assign o_stat.query_occ = r_bitmap[i_query_idx[AW-1:0]];
    assign o_count          = r_count;

endmodule

[rtl/core/slot_table_allocator.sv]
// Top level of the first-fit slot table allocator.
//
// Usage: each transfer on the s_axis side carries one operation in tuser
// (allocate, get or release) and a handle and slot index in tdata. Every
// accepted item gives exactly one result transfer on the m_axis side with a
// status, the granted slot, the handle read back and the occupied-slot count.
// Allocate places a nonzero handle in the lowest empty slot; get reads a slot;
// release empties a slot and returns its former handle.
// An accepted item has its memory read and results registered on acceptance,
// and its result is loaded into the output register in the response state
// once that register is free; no new item is accepted before then.
// Slot occupancy is held in a flip-flop bitmap, so an empty slot reads as zero
// without the memory being cleared, and the lowest free slot is found combinationally.
// Reset clears the bitmap and count, leaving the table empty with no sweep.
// When the receiver stalls, the result waits in the output register; the next
// item is still accepted and completes up to its result, then the block holds
// off further items until the output register frees up.
module slot_table_allocator
    import sta_pkg::*;
#(
    parameter int SLOT_COUNT   = STA_SLOT_COUNT,
    parameter int HANDLE_WIDTH = STA_HANDLE_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Bits from low: handle [31:0], slot_index [39:32].
    input  logic [STA_IN_DW-1:0]  s_axis_tdata,
    // Bits from low: opcode [1:0].
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Bits from low: status [1:0], granted_index [9:2], read_handle [41:10],
    // used_count [50:42], zero fill [55:51].
    output logic [STA_OUT_DW-1:0] m_axis_tdata
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    t_state                r_state;
    t_state                n_state;

    // Item decode.
    t_opcode               w_op;
    logic [STA_HDL_W-1:0]  w_handle_in;
    logic [STA_IDX_W-1:0]  w_idx;
    logic [63:0]           w_handle64;
    logic [HANDLE_WIDTH-1:0] w_handle;
    logic                  w_in_range;
    logic                  w_accept;

    // Occupancy tracker.
    t_occ_upd              w_upd;
    t_occ_stat             w_stat;
    logic [CW-1:0]         w_count;

    // Handle memory.
    logic                  w_we;
    logic                  w_re;
    logic [HANDLE_WIDTH-1:0] w_rdata;
    logic [63:0]           w_rdata64;

    // Item results held across the memory read.
    t_status               r_status;
    t_status               n_status;
    logic [STA_IDX_W-1:0]  r_granted;
    logic [STA_IDX_W-1:0]  n_granted;
    logic                  r_use_rd;
    logic                  n_use_rd;

    // Output register.
    logic                  r_out_valid;
    logic [STA_OUT_DW-1:0] r_out_data;
    logic                  w_load;
    logic [STA_HDL_W-1:0]  w_rd_handle;

    // Payload fields of the input transfer; the handle is cut or widened
    // to the stored width.
    assign w_op        = t_opcode'(s_axis_tuser);
    assign w_handle_in = s_axis_tdata[31:0];
    assign w_idx       = s_axis_tdata[39:32];
    assign w_handle64  = {32'd0, w_handle_in};
    assign w_handle    = w_handle64[HANDLE_WIDTH-1:0];
    assign w_in_range  = ({1'b0, w_idx} < 9'(SLOT_COUNT));
    assign w_accept    = s_axis_tvalid && s_axis_tready;

    // Next state: enter the response state on acceptance, then wait there for the output.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control outputs of the state machine.
    always_comb begin
        s_axis_tready = 1'b0;
        w_load        = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_RESP: begin
                w_load = !r_out_valid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Decide the item at acceptance: memory access, bitmap update and status.
    always_comb begin
        w_upd     = '0;
        w_we      = 1'b0;
        w_re      = 1'b0;
        n_status  = r_status;
        n_granted = r_granted;
        n_use_rd  = r_use_rd;
        if (w_accept) begin
            n_status  = ST_OK;
            n_granted = '0;
            n_use_rd  = 1'b0;
            case (w_op)
                OP_ALLOC: begin
                    if (w_stat.full) begin
                        n_status = ST_FULL;
                    end else if (w_handle == '0) begin
                        n_status = ST_NULL;
                    end else begin
                        w_we        = 1'b1;
                        w_upd.alloc = 1'b1;
                        w_upd.idx   = w_stat.free_idx;
                        n_granted   = w_stat.free_idx;
                    end
                end
                OP_GET, OP_RELEASE: begin
                    if (!w_in_range) begin
                        n_status = ST_RANGE;
                    end else begin
                        w_re      = 1'b1;
                        n_use_rd  = w_stat.query_occ;
                        w_upd.rel = (w_op == OP_RELEASE) && w_stat.query_occ;
                        w_upd.idx = w_idx;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    sta_occupancy #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_occ (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd       (w_upd),
        .i_query_idx (w_idx),
        .o_stat      (w_stat),
        .o_count     (w_count)
    );

    sta_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_stat.free_idx[AW-1:0]),
        .i_wdata (w_handle),
        .i_re    (w_re),
        .i_raddr (w_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Handle read back, forced to zero for an empty slot.
    assign w_rdata64   = 64'(w_rdata);
    assign w_rd_handle = r_use_rd ? w_rdata64[31:0] : '0;

    // State and per-item registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_granted <= n_granted;
        r_use_rd  <= n_use_rd;
    end

    // Output register: loaded from the finished item, cleared on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {5'd0, STA_CNT_W'(w_count), w_rd_handle, r_granted, r_status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // The occupied count never exceeds the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(SLOT_COUNT))
        else $error("occupied count above table size");

    // A table-full result reports a full count.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == ST_FULL))
            |-> (m_axis_tdata[50:42] == 9'(SLOT_COUNT)))
        else $error("table full reported below capacity");

    // A failed item carries no granted slot and no handle.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK))
            |-> (m_axis_tdata[41:2] == '0))
        else $error("failed result carries data");

    // An accepted item is always followed by the response state.
    a_accept_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RESP))
        else $error("accepted item not in progress");
`endif

endmodule

[tb/tb_slot_table_allocator.sv]
// Self-checking testbench for the slot table allocator stream block.
`timescale 1ns / 100ps

module tb_slot_table_allocator
    import sta_pkg::*;
();

    // One result as it should leave the block.
    typedef struct {
        t_status              status;
        logic [STA_IDX_W-1:0] granted;
        logic [STA_HDL_W-1:0] read_handle;
        logic [STA_CNT_W-1:0] used;
    } t_slot_reply;

    // Shadow copy of the slot table and the results it predicts.
    class slot_table_tracker;
        logic [STA_HDL_W-1:0] slots [STA_SLOT_COUNT];
        int unsigned          occupancy;
        t_slot_reply          replies_due [$];
        int unsigned          mismatches;

        function new();
            foreach (slots[k]) slots[k] = '0;
            occupancy  = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        // Apply one accepted operation to the shadow table and queue its reply.
        function void note_request(t_opcode op, logic [STA_HDL_W-1:0] hdl,
                                   logic [STA_IDX_W-1:0] idx);
            t_slot_reply r;
            int          k;
            r.status      = ST_OK;
            r.granted     = '0;
            r.read_handle = '0;
            case (op)
                OP_ALLOC: begin
                    // A full table wins over a null handle.
                    if (occupancy >= STA_SLOT_COUNT) begin
                        r.status = ST_FULL;
                    end else if (hdl == '0) begin
                        r.status = ST_NULL;
                    end else begin
                        r.status = ST_FULL;
                        for (k = 0; k < STA_SLOT_COUNT; k++) begin
                            if (r.status == ST_FULL && slots[k] == '0) begin
                                slots[k]  = hdl;
                                occupancy = occupancy + 1;
                                r.granted = STA_IDX_W'(k);
                                r.status  = ST_OK;
                            end
                        end
                    end
                end
                OP_GET, OP_RELEASE: begin
                    if (idx >= STA_SLOT_COUNT) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.read_handle = slots[idx];
                        // Releasing an empty slot changes nothing.
                        if (op == OP_RELEASE && r.read_handle != '0) begin
                            slots[idx] = '0;
                            occupancy  = occupancy - 1;
                        end
                    end
                end
                default: ;
            endcase
            r.used = STA_CNT_W'(occupancy);
            replies_due.push_back(r);
        endfunction

        task report_mismatch(string what, logic [STA_HDL_W-1:0] got,
                             logic [STA_HDL_W-1:0] want);
            $display("%0t ns: mismatch in %s: got 0x%0h, want 0x%0h",
                     $time, what, got, want);
            mismatches = mismatches + 1;
        endtask

        // Compare one result transfer against the oldest pending reply.
        task check_reply(logic [STA_OUT_DW-1:0] d);
            t_slot_reply want;
            if (replies_due.size() == 0) begin
                report_mismatch("result with nothing pending", d[41:10], '0);
                return;
            end
            want = replies_due.pop_front();
            if (d[1:0] !== want.status)
                report_mismatch("status", d[1:0], want.status);
            if (d[9:2] !== want.granted)
                report_mismatch("granted_index", d[9:2], want.granted);
            if (d[41:10] !== want.read_handle)
                report_mismatch("read_handle", d[41:10], want.read_handle);
            if (d[50:42] !== want.used)
                report_mismatch("used_count", d[50:42], want.used);
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [STA_IN_DW-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [STA_OUT_DW-1:0] m_axis_tdata;

    slot_table_tracker tracker;
    bit                steady;

    slot_table_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 4 ns clock.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watch both sides at the rising edge; results are checked before new
    // operations are noted, which is order-safe as a result is registered before it can leave.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_reply(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_request(t_opcode'(s_axis_tuser), s_axis_tdata[31:0],
                                     s_axis_tdata[39:32]);
        end
    end

    // Present one operation after a random gap and hold it until the transfer.
    task automatic send_op(input t_opcode op, input logic [STA_HDL_W-1:0] hdl,
                           input logic [STA_IDX_W-1:0] idx);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, hdl};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Result side: random stalls before each transfer.
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // Stimulus and end of run.
    initial begin
        int                   n;
        int                   r;
        bit                   filling;
        t_opcode              op;
        logic [STA_HDL_W-1:0] hdl;
        logic [STA_IDX_W-1:0] idx;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_NONE;
        steady        = 1'b0;
        filling       = 1'b1;
        tracker       = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Null handle on an empty table, then the handle extremes.
        send_op(OP_ALLOC, '0, '0);
        send_op(OP_ALLOC, 32'hFFFF_FFFF, '0);
        send_op(OP_ALLOC, 32'h0000_0001, 8'hFF);
        send_op(OP_GET, '0, 8'd0);
        send_op(OP_GET, '0, 8'(STA_SLOT_COUNT - 1));
        // Indexes past the end of the table.
        send_op(OP_GET, '0, 8'(STA_SLOT_COUNT));
        send_op(OP_GET, 32'hFFFF_FFFF, 8'hFF);
        send_op(OP_RELEASE, '0, 8'h80);
        // Release a held slot, then the same slot once it is empty.
        send_op(OP_RELEASE, '0, 8'd0);
        send_op(OP_RELEASE, '0, 8'd0);
        // The unused opcode must leave everything alone.
        send_op(OP_NONE, 32'hDEAD_BEEF, 8'd3);
        // The freed slot 0 is reused first, then the table is filled.
        send_op(OP_ALLOC, 32'hA5A5_A5A5, '0);
        repeat (STA_SLOT_COUNT - 2) send_op(OP_ALLOC, $urandom | 32'h1, '0);
        // Full table, alone and together with a null handle.
        send_op(OP_ALLOC, 32'h1234_5678, '0);
        send_op(OP_ALLOC, '0, '0);
        send_op(OP_RELEASE, '0, 8'd7);
        send_op(OP_ALLOC, 32'h8000_0000, '0);

        // Random part: swing between filling and draining the table.
        for (n = 0; n < 450; n++) begin
            if ($urandom_range(0, 39) == 0)
                steady = !steady;
            if (filling && tracker.occupancy == STA_SLOT_COUNT && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if (!filling && tracker.occupancy == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 59) == 0)
                filling = !filling;

            r = $urandom_range(0, 99);
            if (filling)
                op = (r < 55) ? OP_ALLOC : (r < 70) ? OP_GET : (r < 94) ? OP_RELEASE : OP_NONE;
            else
                op = (r < 15) ? OP_ALLOC : (r < 35) ? OP_GET : (r < 94) ? OP_RELEASE : OP_NONE;

            r = $urandom_range(0, 9);
            if (r == 0)
                hdl = '0;
            else if (r == 1)
                hdl = 32'($urandom_range(1, 15));
            else if (r == 2)
                hdl = ~32'($urandom_range(0, 15));
            else
                hdl = $urandom;

            r = $urandom_range(0, 9);
            if (r == 0)
                idx = 8'($urandom_range(0, 255));
            else if (r == 1)
                idx = 8'($urandom_range(STA_SLOT_COUNT, 255));
            else
                idx = 8'($urandom_range(0, STA_SLOT_COUNT - 1));

            send_op(op, hdl, idx);
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then idle before reporting.
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hang guard.
    initial begin
        #200_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[slot_table_allocator.f]
rtl/core/sta_pkg.sv
rtl/core/sta_ram.sv
rtl/core/sta_occupancy.sv
rtl/core/slot_table_allocator.sv
tb/tb_slot_table_allocator.sv
